/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files; obspl_back is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/obspl_pkg.sv */
`default_nettype none
package obspl_pkg;

  localparam int HANDLE_W = 10;
  localparam int TICK_PW  = 12;
  localparam int QTY_W    = 32;
  localparam int TOT_W    = 42;
  localparam int PRIO_W   = 32;
  localparam int BPW      = 64;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_BAD_TICK   = 3'd1;
  localparam logic [2:0] STS_NOT_IN     = 3'd2;
  localparam logic [2:0] STS_FILL_LARGE = 3'd3;
  localparam logic [2:0] STS_POOL_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [TICK_PW-1:0]  price_tick;
    logic [HANDLE_W-1:0] order_handle;
    logic [31:0]         owner_ident;
    logic [63:0]         owner_order_ref;
    logic [63:0]         venue_order_ref;
    logic [QTY_W-1:0]    quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] result_handle;
    logic [PRIO_W-1:0]   order_priority;
    logic [QTY_W-1:0]    order_remaining;
    logic [TOT_W-1:0]    level_total;
    logic                best_valid;
    logic [TICK_PW-1:0]  best_tick;
  } out_item_t;

  typedef enum logic [2:0] {
    K_ADD, K_FILL, K_REMOVE, K_NOP, K_BAD_TICK, K_BAD_HANDLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [TICK_PW-1:0]  tick;
    logic [HANDLE_W-1:0] handle;
    logic [QTY_W-1:0]    qty;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic               inbook;
    logic [TICK_PW-1:0] tick;
    logic [QTY_W-1:0]   rem;
    logic [PRIO_W-1:0]  prio;
  } node_info_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_ADD_LINK, ST_ADD_TAIL, ST_FILL_CHECK,
    ST_FILL_LEVEL, ST_REM_CHECK, ST_REM_LEVEL, ST_BEST_READ, ST_BEST_SCAN
  } back_state_t;

  // Index of the highest set bit, zero for an empty word.
  function automatic logic [5:0] hi_bit(input logic [BPW-1:0] w);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < BPW; i++) begin
      if (w[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Index of the lowest set bit, 63 for an empty word.
  function automatic logic [5:0] lo_bit(input logic [BPW-1:0] w);
    logic [5:0] idx;
    idx = 6'(BPW - 1);
    for (int i = BPW - 1; i >= 0; i--) begin
      if (w[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/order_book_side_price_levels_top.sv */
`default_nettype none
// One side of a price-grid order book. A command item is taken at a rising edge where
// start is high and busy is low; each item produces exactly one result item, shown on
// result for the single cycle in which done is high. The receiver cannot stall, so the
// result must be captured in that cycle. Each command passes through decode, its own
// steps and the best-tick read and scan. An add links the node and, if the level held
// orders, writes the old tail; a fill or remove checks the node and, if it rests and a
// fill is not too large, updates the level; a full pool, other errors found at decode
// and the unused opcode have no steps of their own. The steps follow the chain of
// dependent reads and writes on the registered-read level and node memories, plus the
// two-step bitmap search for the best tick. A two-entry command queue lets the next item
// be taken while one is in work. After reset the block runs a clearing pass that sets
// every level, the node in-book flags, the occupancy bitmap and the free-slot stack;
// busy stays high during that pass. The book side register may be written at any idle
// time and takes effect for the best tick of the next item. Client and order identifiers
// are accepted but not kept, since no result reports them.
module order_book_side_price_levels_top
  import obspl_pkg::*;
#(
  parameter int TICK_COUNT = 4096,
  parameter int POOL_SLOTS = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t cmd,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  output logic          done,
  output out_item_t     result
);

  // Queue toward the back end and its pop and clearing status in return.
  q_port_t   q;
  back_ctl_t ctl;

  obspl_front #(.TICK_COUNT(TICK_COUNT), .POOL_SLOTS(POOL_SLOTS)) u_front (
    .clk, .rst, .start, .busy, .cmd, .ctl, .q);

  obspl_back #(.TICK_COUNT(TICK_COUNT), .POOL_SLOTS(POOL_SLOTS)) u_back (
    .clk, .rst, .q, .ctl, .cfg_we, .cfg_wdata, .done, .result);

endmodule
`default_nettype wire

/* rtl/core/obspl_ram.sv */
`default_nettype none
module obspl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/obspl_front.sv */
`default_nettype none
module obspl_front
  import obspl_pkg::*;
#(
  parameter int TICK_COUNT = 4096,
  parameter int POOL_SLOTS = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  cmd,
  input  wire back_ctl_t ctl,
  output q_port_t        q
);

  localparam int QDEPTH = 2;

  q_entry_t   slots [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  q_entry_t   entry;
  logic       push, pop;

  // Classify the command so the back end can tell legal work from bad ticks, bad handles and the unused opcode.
  always_comb begin
    entry.tick   = cmd.price_tick;
    entry.handle = cmd.order_handle;
    entry.qty    = cmd.quantity;
    case (cmd.opcode)
      OP_ADD:    entry.kind = (int'(cmd.price_tick) >= TICK_COUNT) ? K_BAD_TICK : K_ADD;
      OP_FILL:   entry.kind = (int'(cmd.order_handle) >= POOL_SLOTS) ? K_BAD_HANDLE : K_FILL;
      OP_REMOVE: entry.kind = (int'(cmd.order_handle) >= POOL_SLOTS) ? K_BAD_HANDLE : K_REMOVE;
      default:   entry.kind = K_NOP;
    endcase
  end

  assign busy    = (count == 2'(QDEPTH)) || ctl.clearing;
  assign push    = start && !busy;
  assign pop     = ctl.pop && (count != 2'd0);
  assign q.valid = (count != 2'd0);
  assign q.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/obspl_back.sv */
`default_nettype none
`include "assert_macros.svh"
module obspl_back
  import obspl_pkg::*;
#(
  parameter int TICK_COUNT = 4096,
  parameter int POOL_SLOTS = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_port_t q,
  output back_ctl_t    ctl,
  input  wire logic    cfg_we,
  input  wire logic    cfg_wdata,
  output logic         done,
  output out_item_t    result
);

  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int PTR_W      = $clog2(POOL_SLOTS + 1);
  localparam int TICK_W     = $clog2(TICK_COUNT);
  localparam int WORD_COUNT = (TICK_COUNT + BPW - 1) / BPW;
  localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LVL_W      = 2 * PTR_W + TOT_W + PRIO_W;
  localparam int INFO_W     = $bits(node_info_t);
  localparam int CLR_N      = (TICK_COUNT > POOL_SLOTS) ? TICK_COUNT : POOL_SLOTS;
  localparam int CLR_W      = $clog2(CLR_N);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_SLOTS);

  back_state_t state, state_next;
  q_entry_t    cur, cur_next;
  out_item_t   res, res_next;
  logic        done_next;
  logic        side;
  logic [PTR_W-1:0] free_cnt, free_cnt_next;
  logic [BPW-1:0]   summary, summary_next;
  logic [CLR_W-1:0] clr;
  logic [SLOT_W-1:0] s_reg, s_next;
  logic [PTR_W-1:0]  tail_reg, tail_next, nx_reg, nx_next, pv_reg, pv_next;
  node_info_t        info_reg, info_next;
  logic [5:0]        word_reg, word_next;

  // Memory ports.
  logic              lvl_we, info_we, nxt_we, prv_we, stk_we, occ_we;
  logic [TICK_W-1:0] lvl_waddr, lvl_raddr;
  logic [LVL_W-1:0]  lvl_wdata, lvl_rdata;
  logic [SLOT_W-1:0] info_waddr, info_raddr, nxt_waddr, nxt_raddr;
  logic [SLOT_W-1:0] prv_waddr, prv_raddr, stk_waddr, stk_raddr;
  node_info_t        info_wdata, info_rdata;
  logic [INFO_W-1:0] info_rbits;
  logic [PTR_W-1:0]  nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
  logic [SLOT_W-1:0] stk_wdata, stk_rdata;
  logic [WORD_W-1:0] occ_waddr, occ_raddr;
  logic [BPW-1:0]    occ_wdata, occ_rdata;

  logic [PTR_W-1:0]  lv_head, lv_tail;
  logic [TOT_W-1:0]  lv_tot;
  logic [PRIO_W-1:0] lv_np;
  logic [TOT_W:0]    sum_wide;
  logic [TOT_W-1:0]  tot_new;
  logic [PTR_W-1:0]  head_new, tail_new;
  logic [BPW-1:0]    occ_new, tick_bit;
  logic [5:0]        bit_sel;

  assign lv_head    = lvl_rdata[LVL_W-1 -: PTR_W];
  assign lv_tail    = lvl_rdata[LVL_W-PTR_W-1 -: PTR_W];
  assign lv_tot     = lvl_rdata[PRIO_W +: TOT_W];
  assign lv_np      = lvl_rdata[PRIO_W-1:0];
  assign info_rdata = node_info_t'(info_rbits);

  obspl_ram #(.WIDTH(LVL_W), .DEPTH(TICK_COUNT)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata));
  obspl_ram #(.WIDTH(INFO_W), .DEPTH(POOL_SLOTS)) u_info (
    .clk, .we(info_we), .waddr(info_waddr), .wdata(INFO_W'(info_wdata)),
    .raddr(info_raddr), .rdata(info_rbits));
  obspl_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SLOTS)) u_next (
    .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata));
  obspl_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SLOTS)) u_prev (
    .clk, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata));
  obspl_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  obspl_ram #(.WIDTH(BPW), .DEPTH(WORD_COUNT)) u_occ (
    .clk, .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata));

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    res_next      = res;
    done_next     = 1'b0;
    free_cnt_next = free_cnt;
    summary_next  = summary;
    s_next        = s_reg;
    tail_next     = tail_reg;
    nx_next       = nx_reg;
    pv_next       = pv_reg;
    info_next     = info_reg;
    word_next     = word_reg;
    ctl.pop       = 1'b0;
    ctl.clearing  = (state == ST_CLEAR);

    lvl_we = 1'b0;  lvl_waddr = TICK_W'(cur.tick);  lvl_wdata = '0;
    lvl_raddr = TICK_W'(cur.tick);
    info_we = 1'b0; info_waddr = SLOT_W'(cur.handle); info_wdata = '0;
    info_raddr = SLOT_W'(cur.handle);
    nxt_we = 1'b0;  nxt_waddr = '0; nxt_wdata = NIL; nxt_raddr = SLOT_W'(cur.handle);
    prv_we = 1'b0;  prv_waddr = '0; prv_wdata = NIL; prv_raddr = SLOT_W'(cur.handle);
    stk_we = 1'b0;  stk_waddr = SLOT_W'(free_cnt); stk_wdata = SLOT_W'(cur.handle);
    stk_raddr = SLOT_W'(free_cnt - PTR_W'(1));
    occ_we = 1'b0;  occ_waddr = WORD_W'(cur.tick[11:6]); occ_wdata = '0;
    occ_raddr = WORD_W'(cur.tick[11:6]);

    tick_bit = BPW'(1) << cur.tick[5:0];
    sum_wide = {1'b0, lv_tot} + (TOT_W+1)'(cur.qty);
    tot_new  = '0;
    head_new = lv_head;
    tail_new = lv_tail;
    occ_new  = occ_rdata;
    bit_sel  = side ? lo_bit(occ_rdata) : hi_bit(occ_rdata);

    case (state)
      ST_CLEAR: begin
        lvl_we    = (int'(clr) < TICK_COUNT);
        lvl_waddr = TICK_W'(clr);
        lvl_wdata = {NIL, NIL, {TOT_W{1'b0}}, PRIO_W'(1)};
        info_we    = (int'(clr) < POOL_SLOTS);
        info_waddr = SLOT_W'(clr);
        stk_we    = (int'(clr) < POOL_SLOTS);
        stk_waddr = SLOT_W'(clr);
        stk_wdata = SLOT_W'(POOL_SLOTS - 1 - int'(clr));
        occ_we    = (int'(clr) < WORD_COUNT);
        occ_waddr = WORD_W'(clr);
        if (clr == CLR_W'(CLR_N - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q.valid) begin
          ctl.pop    = 1'b1;
          cur_next   = q.entry;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_next = '0;
        res_next.result_handle = cur.handle;
        state_next = ST_BEST_READ;
        case (cur.kind)
          K_ADD: begin
            res_next.result_handle = '0;
            if (free_cnt == '0) res_next.status = STS_POOL_FULL;
            else state_next = ST_ADD_LINK;
          end
          K_FILL:       state_next = ST_FILL_CHECK;
          K_REMOVE:     state_next = ST_REM_CHECK;
          K_BAD_TICK: begin
            res_next.status        = STS_BAD_TICK;
            res_next.result_handle = '0;
          end
          K_BAD_HANDLE: res_next.status = STS_NOT_IN;
          default:      res_next.status = STS_OK;
        endcase
      end
      ST_ADD_LINK: begin
        s_next    = stk_rdata;
        tail_next = lv_tail;
        tot_new   = sum_wide > {1'b0, TOTAL_MAX} ? TOTAL_MAX : sum_wide[TOT_W-1:0];
        head_new  = (lv_head == NIL) ? PTR_W'(stk_rdata) : lv_head;
        info_we    = 1'b1;
        info_waddr = stk_rdata;
        info_wdata = '{inbook: 1'b1, tick: cur.tick, rem: cur.qty, prio: lv_np};
        nxt_we    = 1'b1; nxt_waddr = stk_rdata; nxt_wdata = NIL;
        prv_we    = 1'b1; prv_waddr = stk_rdata; prv_wdata = lv_tail;
        lvl_we    = 1'b1;
        lvl_wdata = {head_new, PTR_W'(stk_rdata), tot_new, lv_np + PRIO_W'(1)};
        free_cnt_next = free_cnt - PTR_W'(1);
        res_next.status          = STS_OK;
        res_next.result_handle   = HANDLE_W'(stk_rdata);
        res_next.order_priority  = lv_np;
        res_next.order_remaining = cur.qty;
        res_next.level_total     = tot_new;
        if (lv_head == NIL) begin
          occ_we    = 1'b1;
          occ_wdata = occ_rdata | tick_bit;
          summary_next = summary | (BPW'(1) << cur.tick[11:6]);
          state_next = ST_BEST_READ;
        end else begin
          state_next = ST_ADD_TAIL;
        end
      end
      ST_ADD_TAIL: begin
        nxt_we     = 1'b1;
        nxt_waddr  = SLOT_W'(tail_reg);
        nxt_wdata  = PTR_W'(s_reg);
        state_next = ST_BEST_READ;
      end
      ST_FILL_CHECK: begin
        state_next = ST_BEST_READ;
        if (!info_rdata.inbook) begin
          res_next.status = STS_NOT_IN;
        end else if (cur.qty > info_rdata.rem) begin
          res_next.status = STS_FILL_LARGE;
        end else begin
          info_next     = info_rdata;
          info_next.rem = info_rdata.rem - cur.qty;
          info_we       = 1'b1;
          info_wdata    = info_next;
          lvl_raddr     = TICK_W'(info_rdata.tick);
          state_next    = ST_FILL_LEVEL;
        end
      end
      ST_FILL_LEVEL: begin
        tot_new   = (lv_tot > TOT_W'(cur.qty)) ? lv_tot - TOT_W'(cur.qty) : '0;
        lvl_we    = 1'b1;
        lvl_waddr = TICK_W'(info_reg.tick);
        lvl_wdata = {lv_head, lv_tail, tot_new, lv_np};
        res_next.status          = STS_OK;
        res_next.order_priority  = info_reg.prio;
        res_next.order_remaining = info_reg.rem;
        res_next.level_total     = tot_new;
        state_next = ST_BEST_READ;
      end
      ST_REM_CHECK: begin
        state_next = ST_BEST_READ;
        if (!info_rdata.inbook) begin
          res_next.status = STS_NOT_IN;
        end else begin
          info_next  = info_rdata;
          nx_next    = nxt_rdata;
          pv_next    = prv_rdata;
          info_we    = 1'b1;
          info_wdata = '0;
          lvl_raddr  = TICK_W'(info_rdata.tick);
          occ_raddr  = WORD_W'(info_rdata.tick[11:6]);
          state_next = ST_REM_LEVEL;
        end
      end
      ST_REM_LEVEL: begin
        tick_bit = BPW'(1) << info_reg.tick[5:0];
        head_new = (pv_reg != NIL) ? lv_head : nx_reg;
        tail_new = (nx_reg != NIL) ? lv_tail : pv_reg;
        tot_new  = (lv_tot > TOT_W'(info_reg.rem)) ? lv_tot - TOT_W'(info_reg.rem) : '0;
        lvl_we    = 1'b1;
        lvl_waddr = TICK_W'(info_reg.tick);
        if (head_new == NIL) begin
          // The level has emptied: back to its initial state.
          tot_new   = '0;
          lvl_wdata = {NIL, NIL, {TOT_W{1'b0}}, PRIO_W'(1)};
          occ_new   = occ_rdata & ~tick_bit;
          occ_we    = 1'b1;
          occ_waddr = WORD_W'(info_reg.tick[11:6]);
          occ_wdata = occ_new;
          if (occ_new == '0) summary_next = summary & ~(BPW'(1) << info_reg.tick[11:6]);
        end else begin
          lvl_wdata = {head_new, tail_new, tot_new, lv_np};
        end
        nxt_we    = (pv_reg != NIL);
        nxt_waddr = SLOT_W'(pv_reg);
        nxt_wdata = nx_reg;
        prv_we    = (nx_reg != NIL);
        prv_waddr = SLOT_W'(nx_reg);
        prv_wdata = pv_reg;
        if (free_cnt < PTR_W'(POOL_SLOTS)) begin
          stk_we        = 1'b1;
          free_cnt_next = free_cnt + PTR_W'(1);
        end
        res_next.status          = STS_OK;
        res_next.order_priority  = info_reg.prio;
        res_next.order_remaining = info_reg.rem;
        res_next.level_total     = tot_new;
        state_next = ST_BEST_READ;
      end
      ST_BEST_READ: begin
        word_next  = side ? lo_bit(summary) : hi_bit(summary);
        occ_raddr  = WORD_W'(word_next);
        state_next = ST_BEST_SCAN;
      end
      ST_BEST_SCAN: begin
        res_next.best_valid = (summary != '0);
        res_next.best_tick  = (summary != '0) ? {word_reg, bit_sel} : '0;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      done     <= 1'b0;
      side     <= 1'b0;
      free_cnt <= PTR_W'(POOL_SLOTS);
      summary  <= '0;
      clr      <= '0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      free_cnt <= free_cnt_next;
      summary  <= summary_next;
      if (state == ST_CLEAR) clr <= clr + CLR_W'(1);
      if (cfg_we) side <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    res      <= res_next;
    s_reg    <= s_next;
    tail_reg <= tail_next;
    nx_reg   <= nx_next;
    pv_reg   <= pv_next;
    info_reg <= info_next;
    word_reg <= word_next;
  end

  assign result = res;

  `ASSERT_AT(a_free_cnt_bound, clk, rst, free_cnt <= PTR_W'(POOL_SLOTS), "free count above pool size")
  `ASSERT_AT(a_scan_gives_result, clk, rst, (state == ST_BEST_SCAN) |=> done, "best scan without result")
  `ASSERT_AT(a_no_result_in_clear, clk, rst, (state == ST_CLEAR) |-> !done, "result during clearing pass")

endmodule
`default_nettype wire

/* tb/order_book_side_price_levels_top_tb.sv */
`default_nettype none
module order_book_side_price_levels_top_tb;
  import obspl_pkg::*;

  localparam int TICKS      = 4096;
  localparam int SLOTS      = 1024;
  localparam int WORDS      = TICKS / BPW;
  localparam logic [10:0] NIL = 11'(SLOTS);
  localparam logic [12:0] NO_BEST = 13'h1FFF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  // Worst-case back-end latency plus margin, used before side writes and at the end.
  localparam int SETTLE_CYCLES = 16;

  // Shadow of one book side: node pool, price levels and occupancy bitmap. Each accepted
  // command item is applied here and the result it must produce is queued for checking.
  class side_book_model;
    logic [10:0] nxt [SLOTS];
    logic [10:0] prv [SLOTS];
    bit          inbook [SLOTS];
    logic [11:0] node_tick [SLOTS];
    logic [31:0] node_rem [SLOTS];
    logic [31:0] node_prio [SLOTS];
    logic [9:0]  free_stack [SLOTS];
    int          free_count;
    logic [10:0] head [TICKS];
    logic [10:0] tail [TICKS];
    logic [41:0] total [TICKS];
    logic [31:0] next_prio [TICKS];
    logic [63:0] occ [WORDS];
    logic [63:0] summary;
    logic [12:0] best;
    bit          side;
    int          live [$];
    out_item_t   pending [$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        inbook[i] = 0;
        free_stack[i] = 10'(SLOTS - 1 - i);
        nxt[i] = NIL;
        prv[i] = NIL;
      end
      free_count = SLOTS;
      for (int t = 0; t < TICKS; t++) begin
        head[t] = NIL;
        tail[t] = NIL;
        total[t] = '0;
        next_prio[t] = 32'd1;
      end
      for (int w = 0; w < WORDS; w++) occ[w] = '0;
      summary = '0;
      best = NO_BEST;
      side = 0;
      errors = 0;
    endfunction

    // Highest tick for the buy side, lowest for the sell side.
    function logic [12:0] best_tick_of();
      int w;
      int b;
      if (summary == 0) return NO_BEST;
      w = 0;
      b = 0;
      if (!side) begin
        for (int i = 0; i < 64; i++) if (summary[i]) w = i;
        for (int i = 0; i < 64; i++) if (occ[w][i]) b = i;
      end else begin
        w = 63;
        b = 63;
        for (int i = 63; i >= 0; i--) if (summary[i]) w = i;
        for (int i = 63; i >= 0; i--) if (occ[w][i]) b = i;
      end
      return 13'(w * BPW + b);
    endfunction

    function void set_side(bit v);
      side = v;
      best = best_tick_of();
    endfunction

    function void apply_cmd(in_item_t c);
      out_item_t r;
      int h;
      int s;
      int t;
      int idx;
      logic [42:0] sum;
      logic [10:0] nx;
      logic [10:0] pv;
      r = '0;
      h = c.order_handle;
      t = c.price_tick;
      if (c.opcode == OP_ADD) begin
        if (free_count == 0) begin
          r.status = STS_POOL_FULL;
        end else begin
          free_count--;
          s = free_stack[free_count];
          nxt[s] = NIL;
          prv[s] = tail[t];
          inbook[s] = 1;
          node_tick[s] = 12'(t);
          node_rem[s] = c.quantity;
          node_prio[s] = next_prio[t];
          next_prio[t] = next_prio[t] + 32'd1;
          if (head[t] == NIL) begin
            head[t] = 11'(s);
            occ[t / BPW][t % BPW] = 1'b1;
            summary[t / BPW] = 1'b1;
            if (best == NO_BEST || (!side ? t > best : t < best)) best = 13'(t);
          end else begin
            nxt[tail[t]] = 11'(s);
          end
          tail[t] = 11'(s);
          sum = {1'b0, total[t]} + 43'(c.quantity);
          total[t] = sum[42] ? TOTAL_MAX : sum[41:0];
          live.push_back(s);
          r.result_handle = 10'(s);
          r.order_priority = node_prio[s];
          r.order_remaining = c.quantity;
          r.level_total = total[t];
        end
      end else if (c.opcode == OP_UNUSED) begin
        r.result_handle = c.order_handle;
      end else begin
        r.result_handle = c.order_handle;
        if (!inbook[h]) begin
          r.status = STS_NOT_IN;
        end else begin
          t = node_tick[h];
          if (c.opcode == OP_FILL) begin
            if (c.quantity > node_rem[h]) begin
              r.status = STS_FILL_LARGE;
            end else begin
              node_rem[h] = node_rem[h] - c.quantity;
              total[t] = total[t] > 42'(c.quantity) ? total[t] - 42'(c.quantity) : '0;
              r.order_priority = node_prio[h];
              r.order_remaining = node_rem[h];
              r.level_total = total[t];
            end
          end else begin
            nx = nxt[h];
            pv = prv[h];
            if (pv != NIL) nxt[pv] = nx;
            else head[t] = nx;
            if (nx != NIL) prv[nx] = pv;
            else tail[t] = pv;
            total[t] = total[t] > 42'(node_rem[h]) ? total[t] - 42'(node_rem[h]) : '0;
            nxt[h] = NIL;
            prv[h] = NIL;
            inbook[h] = 0;
            if (head[t] == NIL) begin
              total[t] = '0;
              next_prio[t] = 32'd1;
              occ[t / BPW][t % BPW] = 1'b0;
              if (occ[t / BPW] == 0) summary[t / BPW] = 1'b0;
              if (13'(t) == best) best = best_tick_of();
            end
            free_stack[free_count] = 10'(h);
            free_count++;
            idx = -1;
            foreach (live[i]) if (live[i] == h) idx = i;
            if (idx >= 0) live.delete(idx);
            r.order_priority = node_prio[h];
            r.order_remaining = node_rem[h];
            r.level_total = total[t];
          end
        end
      end
      r.best_valid = (best != NO_BEST);
      r.best_tick = (best != NO_BEST) ? best[11:0] : '0;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing outstanding: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("status", 64'(e.status), 64'(a.status));
      compare_field("result_handle", 64'(e.result_handle), 64'(a.result_handle));
      compare_field("order_priority", 64'(e.order_priority), 64'(a.order_priority));
      compare_field("order_remaining", 64'(e.order_remaining), 64'(a.order_remaining));
      compare_field("level_total", 64'(e.level_total), 64'(a.level_total));
      compare_field("best_valid", 64'(e.best_valid), 64'(a.best_valid));
      compare_field("best_tick", 64'(e.best_tick), 64'(a.best_tick));
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      start = 0;
  logic      busy;
  in_item_t  cmd = '0;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;
  logic      done;
  out_item_t result;

  side_book_model book = new();
  int  cycles = 0;
  // When set, the sender never inserts gaps between command items.
  bit  back_to_back = 0;

  order_book_side_price_levels_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Results cannot be held off, so every strobed cycle is checked as it happens.
  always @(posedge clk) begin
    if (!rst && done) book.check_result(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one command item and holds it until the block takes it. The item counts as
  // accepted at the edge where start was high and busy (its value before the edge) low.
  // Start is lowered only when a gap follows, so each edge carries a single update.
  task automatic send(in_item_t c);
    int gap;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    book.apply_cmd(c);
    if (!back_to_back && $urandom_range(99) < 27) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding result item has come back, then
  // lets the block settle, since a late command may still be in its pipeline.
  task automatic drain();
    start <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(bit v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_side(v);
  endtask

  function automatic in_item_t base_item(logic [1:0] op);
    in_item_t c;
    c.opcode = op;
    c.price_tick = 12'($urandom);
    c.order_handle = 10'($urandom);
    c.owner_ident = $urandom;
    c.owner_order_ref = {$urandom, $urandom};
    c.venue_order_ref = {$urandom, $urandom};
    c.quantity = $urandom;
    return c;
  endfunction

  // Ticks mostly fall in a narrow window across a bitmap word boundary so that levels
  // stack several orders deep and empty out again; the rest spread over the whole grid.
  function automatic logic [11:0] pick_tick();
    if ($urandom_range(99) < 75) return 12'($urandom_range(2040, 2100));
    return 12'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t c;
    int roll;
    int h;
    roll = $urandom_range(99);
    if (roll < 40 || book.live.size() == 0) begin
      c = base_item(OP_ADD);
      c.price_tick = pick_tick();
      if ($urandom_range(3) == 0) c.quantity = $urandom_range(0, 1000);
    end else if (roll < 65) begin
      c = base_item(OP_FILL);
      h = book.live[$urandom_range(book.live.size() - 1)];
      c.order_handle = 10'(h);
      if ($urandom_range(9) == 0) begin
        if (book.node_rem[h] != '1) c.quantity = $urandom_range(book.node_rem[h] + 1, 32'hFFFF_FFFF);
      end else if ($urandom_range(4) == 0) begin
        c.quantity = book.node_rem[h];
      end else begin
        c.quantity = $urandom_range(0, book.node_rem[h]);
      end
    end else if (roll < 90) begin
      c = base_item(OP_REMOVE);
      c.order_handle = 10'(book.live[$urandom_range(book.live.size() - 1)]);
    end else begin
      // Noise: stale or random handles and the unused opcode.
      c = base_item(2'($urandom_range(1, 3)));
    end
    return c;
  endfunction

  initial begin
    in_item_t c;
    int h0;
    int h1;
    int h2;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // The clearing pass after reset keeps busy high; wait it out before configuring.
    @(posedge clk);
    while (busy) @(posedge clk);
    write_side(1'b0);

    // Directed part. Extreme ticks and sizes, all-ones and all-zero identifiers.
    c = '0;
    c.opcode = OP_ADD;
    c.price_tick = 12'd0;
    c.quantity = 32'hFFFF_FFFF;
    send(c);
    h0 = book.live[$];
    c = '1;
    c.opcode = OP_ADD;
    c.price_tick = 12'hFFF;
    c.quantity = 32'd0;
    send(c);
    c.quantity = 32'd500;
    send(c);
    h1 = book.live[$];
    c.quantity = 32'hFFFF_FFFF;
    send(c);
    h2 = book.live[$];
    // A fill of zero, an exact fill, and one larger than what remains.
    c = base_item(OP_FILL);
    c.order_handle = 10'(h1);
    c.quantity = 32'd0;
    send(c);
    c.quantity = 32'd500;
    send(c);
    c.quantity = 32'd1;
    send(c);
    // Remove from the middle of a level, then from its tail.
    c = base_item(OP_REMOVE);
    c.order_handle = 10'(h1);
    send(c);
    c.order_handle = 10'(h2);
    send(c);
    // Handles that are not resting: one just freed and the highest slot.
    send(c);
    c = base_item(OP_FILL);
    c.order_handle = 10'h3FF;
    send(c);
    c = base_item(OP_UNUSED);
    c.order_handle = 10'h3FF;
    send(c);
    c = base_item(OP_UNUSED);
    c.order_handle = '0;
    send(c);
    // Side switch with levels at both ends of the grid.
    write_side(1'b1);
    c = base_item(OP_ADD);
    c.price_tick = 12'd63;
    send(c);
    c.price_tick = 12'd64;
    send(c);
    // Emptying the best level makes the block search for the next one; freed slot
    // reuse is last-in first-out.
    c = base_item(OP_REMOVE);
    c.order_handle = 10'(h0);
    send(c);
    c = base_item(OP_ADD);
    c.price_tick = 12'd0;
    send(c);

    // Random traffic on the sell side.
    repeat (300) send(random_item());
    write_side(1'b0);

    // Fill the whole pool back to back, then a few adds that find it full.
    back_to_back = 1;
    while (book.free_count > 0) begin
      c = base_item(OP_ADD);
      c.price_tick = pick_tick();
      send(c);
    end
    back_to_back = 0;
    repeat (6) begin
      c = base_item(OP_ADD);
      send(c);
    end

    repeat (150) send(random_item());
    write_side(1'b1);
    repeat (150) send(random_item());
    write_side(1'b0);

    drain();
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
